// ===== sv/tdt_pkg.sv =====
// Shared types, constants and IEEE double compare functions for the triangle dedup table.
`default_nettype none
package tdt_pkg;

    localparam int MAX_TRIANGLES = 1024;
    localparam int MAX_VERTICES  = 1024;

    typedef logic [63:0]  t_f64;
    // One vertex as {x, y, z}, x in the top word.
    typedef logic [191:0] t_vtx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_TSCAN,
        S_VSCAN,
        S_MERGE,
        S_WRITE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic hit;
        logic found;
    } t_lane_st;

    typedef struct packed {
        logic [2:0] fresh;
        logic [1:0] nnew;
        logic       full;
    } t_merge_ctl;

    function automatic logic f64_nan(t_f64 a);
        return (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    endfunction

    function automatic logic f64_eq(t_f64 a, t_f64 b);
        return !f64_nan(a) && !f64_nan(b) &&
               ((a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)));
    endfunction

    function automatic logic f64_lt(t_f64 a, t_f64 b);
        logic r;
        begin
            if (f64_nan(a) || f64_nan(b)) begin
                r = 1'b0;
            end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
                r = 1'b0;
            end else if (a[63] != b[63]) begin
                r = a[63];
            end else if (!a[63]) begin
                r = a[62:0] < b[62:0];
            end else begin
                r = a[62:0] > b[62:0];
            end
            return r;
        end
    endfunction

    function automatic logic vtx_eq(t_vtx a, t_vtx b);
        return f64_eq(a[191:128], b[191:128]) && f64_eq(a[127:64], b[127:64]) &&
               f64_eq(a[63:0], b[63:0]);
    endfunction

    // Lexicographic greater-than; a NaN coordinate leaves the decision to the next one.
    function automatic logic vtx_gt(t_vtx a, t_vtx b);
        logic r;
        logic done;
        t_f64 x;
        t_f64 y;
        begin
            r    = 1'b0;
            done = 1'b0;
            for (int k = 0; k < 3; k++) begin
                x = a[191 - 64 * k -: 64];
                y = b[191 - 64 * k -: 64];
                if (!done) begin
                    if (f64_lt(x, y)) begin
                        done = 1'b1;
                        r    = 1'b0;
                    end else if (f64_lt(y, x)) begin
                        done = 1'b1;
                        r    = 1'b1;
                    end
                end
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/tdt_if.sv =====
// Valid/ready channel interfaces for triangle beats and result beats.
`default_nettype none
interface tdt_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] v0_x;
    logic [63:0] v0_y;
    logic [63:0] v0_z;
    logic [63:0] v1_x;
    logic [63:0] v1_y;
    logic [63:0] v1_z;
    logic [63:0] v2_x;
    logic [63:0] v2_y;
    logic [63:0] v2_z;

    modport source (output valid, output operation, output v0_x, output v0_y, output v0_z,
                    output v1_x, output v1_y, output v1_z, output v2_x, output v2_y,
                    output v2_z, input ready);
    modport sink (input valid, input operation, input v0_x, input v0_y, input v0_z,
                  input v1_x, input v1_y, input v1_z, input v2_x, input v2_y,
                  input v2_z, output ready);
endinterface

interface tdt_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  triangle_id;
    logic        is_new;
    logic        status;
    logic [9:0]  vertex_index_0;
    logic [9:0]  vertex_index_1;
    logic [9:0]  vertex_index_2;
    logic [10:0] triangle_total;
    logic [10:0] vertex_total;

    modport source (output valid, output triangle_id, output is_new, output status,
                    output vertex_index_0, output vertex_index_1, output vertex_index_2,
                    output triangle_total, output vertex_total, input ready);
    modport sink (input valid, input triangle_id, input is_new, input status,
                  input vertex_index_0, input vertex_index_1, input vertex_index_2,
                  input triangle_total, input vertex_total, output ready);
endinterface
`default_nettype wire

// ===== sv/tdt_lane.sv =====
// One compare lane: vertex equality and first-hit tracking over a store scan.
`default_nettype none
module tdt_lane #(
    parameter int MAX_VERTICES = tdt_pkg::MAX_VERTICES,
    localparam int VW = $clog2(MAX_VERTICES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clr,
    input  wire logic             i_vld,
    input  wire tdt_pkg::t_vtx    i_a,
    input  wire tdt_pkg::t_vtx    i_b,
    input  wire logic [VW-1:0]    i_idx,
    output tdt_pkg::t_lane_st     o_st,
    output logic [VW-1:0]         o_idx
);
    logic          r_found;
    logic [VW-1:0] r_idx;
    logic          hit;

    assign hit = tdt_pkg::vtx_eq(i_a, i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clr) begin
            r_found <= 1'b0;
        end else if (i_vld && hit && !r_found) begin
            r_found <= 1'b1;
        end
    end

    // Only the lowest matching index is kept.
    always_ff @(posedge i_clk) begin
        if (i_vld && hit && !r_found && !i_clr) begin
            r_idx <= i_idx;
        end
    end

    assign o_st.hit   = hit;
    assign o_st.found = r_found;
    assign o_idx      = r_idx;
endmodule
`default_nettype wire

// ===== sv/tdt_merge.sv =====
// Merges the three lane results into corner indices, new-vertex flags and the full check.
`default_nettype none
module tdt_merge #(
    parameter int MAX_VERTICES = tdt_pkg::MAX_VERTICES,
    localparam int VW  = $clog2(MAX_VERTICES),
    localparam int VCW = $clog2(MAX_VERTICES + 1)
) (
    input  wire tdt_pkg::t_lane_st   i_st  [3],
    input  wire logic [VW-1:0]       i_idx [3],
    input  wire tdt_pkg::t_vtx       i_tri [3],
    input  wire logic [VCW-1:0]      i_vcnt,
    output logic [VW-1:0]            o_idx [3],
    output tdt_pkg::t_merge_ctl      o_ctl
);
    always_comb begin
        logic          f;
        logic [VW-1:0] id;
        logic [1:0]    cnt;
        o_ctl = '0;
        cnt   = 2'd0;
        for (int i = 0; i < 3; i++) begin
            f  = i_st[i].found;
            id = i_idx[i];
            // A corner repeating an earlier new corner of this triangle reuses its index.
            for (int j = 0; j < i; j++) begin
                if (!f && o_ctl.fresh[j] && tdt_pkg::vtx_eq(i_tri[j], i_tri[i])) begin
                    f  = 1'b1;
                    id = o_idx[j];
                end
            end
            o_ctl.fresh[i] = !f;
            if (!f) begin
                id  = VW'(i_vcnt) + VW'(cnt);
                cnt = cnt + 2'd1;
            end
            o_idx[i] = id;
        end
        o_ctl.nnew = cnt;
        o_ctl.full = ({1'b0, i_vcnt} + (VCW + 1)'(cnt)) > (VCW + 1)'(MAX_VERTICES);
    end
endmodule
`default_nettype wire

// ===== sv/triangle_dedup_table.sv =====
// Top level of the triangle dedup table with vertex welding.
//
//   channel  dir  beat
//   i_in     in   operation and nine coordinate words of one triangle
//   o_res    out  triangle id, new and full flags, corner indices, totals
//
// A triangle is accepted, its key is sorted, the T stored keys and then the V stored
// vertices are scanned one address at a time, the three lane results are merged, and the
// key, corners and new vertices are written before the result goes out; a key match ends
// the key scan at the hit, a full store skips to the output and a clear goes straight there.
// The stores need no clearing pass after reset.
// One item is in work at a time; a finished result waits in the output register.
`default_nettype none
module triangle_dedup_table #(
    parameter int MAX_TRIANGLES = tdt_pkg::MAX_TRIANGLES,
    parameter int MAX_VERTICES  = tdt_pkg::MAX_VERTICES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tdt_in_if.sink     i_in,
    tdt_out_if.source  o_res
);
    localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int TCW = $clog2(MAX_TRIANGLES + 1);
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int AW  = (TCW > VCW) ? TCW : VCW;

    tdt_pkg::t_state r_state, n_state;

    tdt_pkg::t_vtx   r_tri [3];
    tdt_pkg::t_vtx   r_key [3];
    logic [1:0]      r_step;
    logic [TCW-1:0]  r_tcnt;
    logic [VCW-1:0]  r_vcnt;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_pidx;
    logic            r_pend;
    logic [VW-1:0]   r_idx [3];
    logic [2:0]      r_fresh;
    logic [1:0]      r_nnew;
    logic [1:0]      r_wi;

    logic [575:0]    key_mem [MAX_TRIANGLES];
    logic [3*VW-1:0] cor_mem [MAX_TRIANGLES];
    tdt_pkg::t_vtx   vtx_mem [MAX_VERTICES];
    logic [575:0]    r_key_rd;
    logic [3*VW-1:0] r_cor_rd;
    tdt_pkg::t_vtx   r_vtx_rd;

    logic [9:0]      r_s_id;
    logic            r_s_new;
    logic            r_s_full;
    logic [9:0]      r_s_vi [3];
    logic [10:0]     r_s_tt;
    logic [10:0]     r_s_vt;

    logic            r_ov;
    logic [9:0]      r_o_id;
    logic            r_o_new;
    logic            r_o_full;
    logic [9:0]      r_o_vi [3];
    logic [10:0]     r_o_tt;
    logic [10:0]     r_o_vt;

    // Control outputs of the sequencer.
    logic            in_rdy;
    logic            accept;
    logic [AW-1:0]   lim;
    logic            issue;
    logic            key_hit;
    logic            scan_end;
    logic            out_load;
    logic            lane_clr;
    logic            lane_trk;

    tdt_pkg::t_vtx      lane_a [3];
    tdt_pkg::t_vtx      lane_b [3];
    tdt_pkg::t_lane_st  lane_st [3];
    logic [VW-1:0]      lane_idx [3];
    logic [VW-1:0]      mg_idx [3];
    tdt_pkg::t_merge_ctl mg_ctl;

    tdt_pkg::t_vtx   sa;
    tdt_pkg::t_vtx   sb;
    logic            swp;

    // Bubble step: pairs (0,1), (1,2), then (0,1) again.
    always_comb begin
        if (r_step == 2'd1) begin
            sa = r_key[1];
            sb = r_key[2];
        end else begin
            sa = r_key[0];
            sb = r_key[1];
        end
        swp = tdt_pkg::vtx_gt(sa, sb);
    end

    assign accept = i_in.valid && in_rdy;

    always_comb begin
        in_rdy   = 1'b0;
        lim      = '0;
        lane_clr = 1'b0;
        lane_trk = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            tdt_pkg::S_IDLE:  in_rdy = 1'b1;
            tdt_pkg::S_TSCAN: lim = AW'(r_tcnt);
            tdt_pkg::S_VSCAN: begin
                lim      = AW'(r_vcnt);
                lane_trk = r_pend;
            end
            tdt_pkg::S_OUT:   out_load = !r_ov || o_res.ready;
            default: ;
        endcase
        if (r_state == tdt_pkg::S_TSCAN) begin
            lane_clr = 1'b1;
        end
    end

    assign issue    = ((r_state == tdt_pkg::S_TSCAN) || (r_state == tdt_pkg::S_VSCAN)) &&
                      (r_addr < lim);
    assign key_hit  = r_pend && lane_st[0].hit && lane_st[1].hit && lane_st[2].hit;
    assign scan_end = !issue && !r_pend;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = i_in.operation ? tdt_pkg::S_OUT : tdt_pkg::S_SORT;
                end
            end
            tdt_pkg::S_SORT: begin
                if (r_step == 2'd2) begin
                    n_state = tdt_pkg::S_TSCAN;
                end
            end
            tdt_pkg::S_TSCAN: begin
                if (key_hit) begin
                    n_state = tdt_pkg::S_OUT;
                end else if (scan_end) begin
                    n_state = (r_tcnt >= TCW'(MAX_TRIANGLES)) ? tdt_pkg::S_OUT
                                                               : tdt_pkg::S_VSCAN;
                end
            end
            tdt_pkg::S_VSCAN: begin
                if (scan_end) begin
                    n_state = tdt_pkg::S_MERGE;
                end
            end
            tdt_pkg::S_MERGE: n_state = mg_ctl.full ? tdt_pkg::S_OUT : tdt_pkg::S_WRITE;
            tdt_pkg::S_WRITE: begin
                if (r_wi == 2'd2) begin
                    n_state = tdt_pkg::S_OUT;
                end
            end
            tdt_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = tdt_pkg::S_IDLE;
                end
            end
            default: n_state = tdt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign lane_a[k] = (r_state == tdt_pkg::S_TSCAN) ? r_key[k] : r_tri[k];
        assign lane_b[k] = (r_state == tdt_pkg::S_TSCAN) ? r_key_rd[(2 - k) * 192 +: 192]
                                                         : r_vtx_rd;
        tdt_lane #(.MAX_VERTICES(MAX_VERTICES)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (lane_clr),
            .i_vld   (lane_trk),
            .i_a     (lane_a[k]),
            .i_b     (lane_b[k]),
            .i_idx   (VW'(r_pidx)),
            .o_st    (lane_st[k]),
            .o_idx   (lane_idx[k])
        );
    end

    tdt_merge #(.MAX_VERTICES(MAX_VERTICES)) u_merge (
        .i_st   (lane_st),
        .i_idx  (lane_idx),
        .i_tri  (r_tri),
        .i_vcnt (r_vcnt),
        .o_idx  (mg_idx),
        .o_ctl  (mg_ctl)
    );

    // Memories: one registered read per cycle at the scan address.
    always_ff @(posedge i_clk) begin
        r_key_rd <= key_mem[r_addr[TAW-1:0]];
        r_cor_rd <= cor_mem[r_addr[TAW-1:0]];
        r_vtx_rd <= vtx_mem[r_addr[VW-1:0]];
        if ((r_state == tdt_pkg::S_WRITE) && (r_wi == 2'd0)) begin
            key_mem[r_tcnt[TAW-1:0]] <= {r_key[0], r_key[1], r_key[2]};
            cor_mem[r_tcnt[TAW-1:0]] <= {r_idx[0], r_idx[1], r_idx[2]};
        end
        if ((r_state == tdt_pkg::S_WRITE) && r_fresh[r_wi]) begin
            vtx_mem[r_idx[r_wi]] <= r_tri[r_wi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcnt <= '0;
            r_vcnt <= '0;
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_pend <= issue;
            if (accept && i_in.operation) begin
                r_tcnt <= '0;
                r_vcnt <= '0;
            end
            if ((r_state == tdt_pkg::S_WRITE) && (r_wi == 2'd2)) begin
                r_tcnt <= r_tcnt + TCW'(1);
                r_vcnt <= r_vcnt + VCW'(r_nnew);
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_addr;
        if (issue) begin
            r_addr <= r_addr + AW'(1);
        end
        unique case (r_state)
            tdt_pkg::S_IDLE: begin
                r_step <= 2'd0;
                r_addr <= '0;
                r_tri[0] <= {i_in.v0_x, i_in.v0_y, i_in.v0_z};
                r_tri[1] <= {i_in.v1_x, i_in.v1_y, i_in.v1_z};
                r_tri[2] <= {i_in.v2_x, i_in.v2_y, i_in.v2_z};
                r_key[0] <= {i_in.v0_x, i_in.v0_y, i_in.v0_z};
                r_key[1] <= {i_in.v1_x, i_in.v1_y, i_in.v1_z};
                r_key[2] <= {i_in.v2_x, i_in.v2_y, i_in.v2_z};
                r_s_id   <= '0;
                r_s_new  <= 1'b0;
                r_s_full <= 1'b0;
                r_s_vi   <= '{default: '0};
                r_s_tt   <= '0;
                r_s_vt   <= '0;
            end
            tdt_pkg::S_SORT: begin
                r_step <= r_step + 2'd1;
                if (swp) begin
                    if (r_step == 2'd1) begin
                        r_key[1] <= sb;
                        r_key[2] <= sa;
                    end else begin
                        r_key[0] <= sb;
                        r_key[1] <= sa;
                    end
                end
            end
            tdt_pkg::S_TSCAN: begin
                r_s_tt <= 11'(r_tcnt);
                r_s_vt <= 11'(r_vcnt);
                if (key_hit) begin
                    r_s_id    <= 10'(r_pidx);
                    r_s_vi[0] <= 10'(r_cor_rd[3*VW-1 -: VW]);
                    r_s_vi[1] <= 10'(r_cor_rd[2*VW-1 -: VW]);
                    r_s_vi[2] <= 10'(r_cor_rd[VW-1:0]);
                end else if (scan_end) begin
                    r_s_full <= r_tcnt >= TCW'(MAX_TRIANGLES);
                    r_addr   <= '0;
                end
            end
            tdt_pkg::S_MERGE: begin
                r_wi    <= 2'd0;
                r_idx   <= mg_idx;
                r_fresh <= mg_ctl.fresh;
                r_nnew  <= mg_ctl.nnew;
                if (mg_ctl.full) begin
                    r_s_full <= 1'b1;
                end else begin
                    r_s_id    <= 10'(r_tcnt);
                    r_s_new   <= 1'b1;
                    r_s_vi[0] <= 10'(mg_idx[0]);
                    r_s_vi[1] <= 10'(mg_idx[1]);
                    r_s_vi[2] <= 10'(mg_idx[2]);
                    r_s_tt    <= 11'(r_tcnt + TCW'(1));
                    r_s_vt    <= 11'(r_vcnt + VCW'(mg_ctl.nnew));
                end
            end
            tdt_pkg::S_WRITE: r_wi <= r_wi + 2'd1;
            default: ;
        endcase
        if (out_load) begin
            r_o_id   <= r_s_id;
            r_o_new  <= r_s_new;
            r_o_full <= r_s_full;
            r_o_vi   <= r_s_vi;
            r_o_tt   <= r_s_tt;
            r_o_vt   <= r_s_vt;
        end
    end

    assign i_in.ready           = in_rdy;
    assign o_res.valid          = r_ov;
    assign o_res.triangle_id    = r_o_id;
    assign o_res.is_new         = r_o_new;
    assign o_res.status         = r_o_full;
    assign o_res.vertex_index_0 = r_o_vi[0];
    assign o_res.vertex_index_1 = r_o_vi[1];
    assign o_res.vertex_index_2 = r_o_vi[2];
    assign o_res.triangle_total = r_o_tt;
    assign o_res.vertex_total   = r_o_vt;

    a_vcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= VCW'(MAX_VERTICES)) else $error("vertex count above capacity");
    a_tcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcnt <= TCW'(MAX_TRIANGLES)) else $error("triangle count above capacity");
    a_full_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_full |-> !r_o_new) else $error("full result flagged as new");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.operation |=> (r_tcnt == '0) && (r_vcnt == '0))
        else $error("clear left stored counts");
endmodule
`default_nettype wire
